// File: rtl/epoch_seconds_to_calendar_core_defines.svh
// Assertion macros used by the checker file of the calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ESC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar core check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ESC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar core check failed");

`endif

// File: rtl/esc_pkg.sv
// Constants and helper functions for the epoch seconds to calendar converter.
package esc_pkg;

    localparam int unsigned SEC_PER_MIN   = 60;
    localparam int unsigned MIN_PER_HOUR  = 60;
    localparam int unsigned HOUR_PER_DAY  = 24;
    localparam int unsigned DAY_PER_WEEK  = 7;
    localparam int unsigned MONTH_PER_YR  = 12;

    // Reciprocal multipliers: x/15 for x < 2^32, x/3 for x < 2^19,
    // x/7 for x < 2^18, x/1461 for x < 2^16.
    localparam logic [31:0] DIV15_MAGIC   = 32'h8888_8889;
    localparam logic [17:0] DIV3_MAGIC    = 18'h2_AAAB;
    localparam logic [17:0] DIV7_MAGIC    = 18'd149797;
    localparam logic [16:0] DIV1461_MAGIC = 17'd91868;

    localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;

    // Day counting restarts at 1968-01-01, the leap year ahead of the epoch.
    localparam logic [15:0] EPOCH_DAY_OFS = 16'd731;
    localparam logic [7:0]  BASE_YS       = 8'd68;
    localparam logic [2:0]  EPOCH_WD_OFS  = 3'd4;

    // 2100 is the only century year in range that is not a leap year.
    localparam logic [15:0] DAY_2100_MAR1 = 16'd47541;
    localparam logic [7:0]  YS_2100       = 8'd200;
    localparam logic [8:0]  YDAY_MAR1_LP  = 9'd60;

    // Start of each year within a four-year cycle, leap year first.
    localparam logic [10:0] QUAD_YR1 = 11'd366;
    localparam logic [10:0] QUAD_YR2 = 11'd731;
    localparam logic [10:0] QUAD_YR3 = 11'd1096;

    function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        unique case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && mon >= 4'd2) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// File: rtl/epoch_seconds_to_calendar_core.sv
// Pipelined conversion of epoch seconds into Gregorian calendar fields.
//
//   channel  | valid         | ready         | payload
//   ---------+---------------+---------------+---------------------------------
//   input    | i_in_valid    | o_in_ready    | i_epoch_seconds
//   output   | o_out_valid   | i_out_ready   | o_second .. o_day_of_month
//
// Six register stages; a request passes through all six before it is offered at
// the output; a new request can be accepted every cycle unless all are stalled.
// The stage count is set by the reciprocal multipliers: one per stage for the
// divisions by 60, 60, 24 and 1461, then the year and month selection.
// Each stage holds while the stage after it is full and stalled, so empty
// stages close up and nothing is dropped or repeated.
// Reset empties the pipeline; payload registers are not reset.
module epoch_seconds_to_calendar_core
    import esc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [2:0]  o_weekday,
    output logic [7:0]  o_years_since_1900,
    output logic [8:0]  o_day_of_year,
    output logic [3:0]  o_month_index,
    output logic [4:0]  o_day_of_month
);

    logic [6:1] r_vld;
    logic [6:1] n_vld;
    logic [7:1] w_rdy;

    always_comb begin
        w_rdy[7] = i_out_ready;
        for (int k = 6; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_rdy[1]) begin
            n_vld[1] = i_in_valid;
        end
        for (int k = 2; k <= 6; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_rdy[1];
    assign o_out_valid = r_vld[6];

    // Stage 1: minutes = seconds / 60, taken as (seconds / 4) / 15.
    logic [61:0] w_p1;
    logic [26:0] r1_q1;
    logic [5:0]  r1_slo;

    assign w_p1 = i_epoch_seconds[31:2] * DIV15_MAGIC;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_q1  <= w_p1[61:35];
            r1_slo <= i_epoch_seconds[5:0];
        end
    end

    // Stage 2: second, and hours = minutes / 60.
    logic [11:0] w_m1;
    logic [5:0]  w_sec;
    logic [56:0] w_p2;
    logic [5:0]  r2_sec;
    logic [5:0]  r2_q1lo;
    logic [20:0] r2_q2;

    assign w_m1  = r1_q1[5:0] * 6'(SEC_PER_MIN);
    assign w_sec = r1_slo - w_m1[5:0];
    assign w_p2  = r1_q1[26:2] * DIV15_MAGIC;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r2_sec  <= w_sec;
            r2_q1lo <= r1_q1[5:0];
            r2_q2   <= w_p2[55:35];
        end
    end

    // Stage 3: minute, and days = hours / 24, taken as (hours / 8) / 3.
    logic [11:0] w_m2;
    logic [5:0]  w_min;
    logic [35:0] w_p3;
    logic [5:0]  r3_sec;
    logic [5:0]  r3_min;
    logic [4:0]  r3_q2lo;
    logic [15:0] r3_days;

    assign w_m2  = r2_q2[5:0] * 6'(MIN_PER_HOUR);
    assign w_min = r2_q1lo - w_m2[5:0];
    assign w_p3  = r2_q2[20:3] * DIV3_MAGIC;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r3_sec  <= r2_sec;
            r3_min  <= w_min;
            r3_q2lo <= r2_q2[4:0];
            r3_days <= w_p3[34:19];
        end
    end

    // Stage 4: hour, weekday quotient, and the four-year cycle number.
    // Past 2100-02-28 one day is added so every cycle counts 1461 days.
    logic [9:0]  w_m3;
    logic [4:0]  w_hr;
    logic [16:0] w_x;
    logic [34:0] w_p7;
    logic        w_past_2100;
    logic [15:0] w_n;
    logic [32:0] w_p4;
    logic [5:0]  r4_sec;
    logic [5:0]  r4_min;
    logic [4:0]  r4_hr;
    logic [2:0]  r4_xlo;
    logic [2:0]  r4_q7lo;
    logic [15:0] r4_n;
    logic [5:0]  r4_cycle;

    assign w_m3        = r3_days[4:0] * 5'(HOUR_PER_DAY);
    assign w_hr        = r3_q2lo - w_m3[4:0];
    assign w_x         = {1'b0, r3_days} + {14'd0, EPOCH_WD_OFS};
    assign w_p7        = w_x * DIV7_MAGIC;
    assign w_past_2100 = (r3_days >= DAY_2100_MAR1);
    assign w_n         = r3_days + EPOCH_DAY_OFS + {15'd0, w_past_2100};
    assign w_p4        = w_n * DIV1461_MAGIC;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r4_sec   <= r3_sec;
            r4_min   <= r3_min;
            r4_hr    <= w_hr;
            r4_xlo   <= w_x[2:0];
            r4_q7lo  <= w_p7[22:20];
            r4_n     <= w_n;
            r4_cycle <= w_p4[32:27];
        end
    end

    // Stage 5: weekday, year and day of year, with the 2100 correction.
    logic [5:0]  w_m7;
    logic [2:0]  w_wd;
    logic [16:0] w_cyc_days;
    logic [10:0] w_r;
    logic [1:0]  w_yoc;
    logic [10:0] w_ystart;
    logic [10:0] w_yd_full;
    logic [8:0]  w_yd0;
    logic [7:0]  w_ys;
    logic        w_is_2100;
    logic        w_leap;
    logic [8:0]  w_yday;
    logic [5:0]  r5_sec;
    logic [5:0]  r5_min;
    logic [4:0]  r5_hr;
    logic [2:0]  r5_wd;
    logic [7:0]  r5_ys;
    logic [8:0]  r5_yday;
    logic        r5_leap;

    assign w_m7       = r4_q7lo * 3'(DAY_PER_WEEK);
    assign w_wd       = r4_xlo - w_m7[2:0];
    assign w_cyc_days = r4_cycle * DAYS_PER_QUAD;
    assign w_r        = r4_n[10:0] - w_cyc_days[10:0];

    always_comb begin
        if (w_r >= QUAD_YR3) begin
            w_yoc    = 2'd3;
            w_ystart = QUAD_YR3;
        end else if (w_r >= QUAD_YR2) begin
            w_yoc    = 2'd2;
            w_ystart = QUAD_YR2;
        end else if (w_r >= QUAD_YR1) begin
            w_yoc    = 2'd1;
            w_ystart = QUAD_YR1;
        end else begin
            w_yoc    = 2'd0;
            w_ystart = '0;
        end
    end

    assign w_yd_full = w_r - w_ystart;
    assign w_yd0     = w_yd_full[8:0];
    assign w_ys      = BASE_YS + {r4_cycle, 2'b00} + {6'd0, w_yoc};
    assign w_is_2100 = (w_ys == YS_2100);
    assign w_leap    = (w_yoc == 2'd0) && !w_is_2100;
    // The skipped February 29 of 2100 shifts the rest of that year by one.
    assign w_yday    = (w_is_2100 && w_yd0 >= YDAY_MAR1_LP) ? w_yd0 - 9'd1 : w_yd0;

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r5_sec  <= r4_sec;
            r5_min  <= r4_min;
            r5_hr   <= r4_hr;
            r5_wd   <= w_wd;
            r5_ys   <= w_ys;
            r5_yday <= w_yday;
            r5_leap <= w_leap;
        end
    end

    // Stage 6: month and day of month from the day of year.
    logic [3:0] w_mon;
    logic [8:0] w_dom_full;

    always_comb begin
        w_mon = '0;
        for (int k = 1; k < MONTH_PER_YR; k++) begin
            if (r5_yday >= month_start(4'(k), r5_leap)) begin
                w_mon = 4'(k);
            end
        end
    end

    assign w_dom_full = r5_yday - month_start(w_mon, r5_leap) + 9'd1;

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            o_second           <= r5_sec;
            o_minute           <= r5_min;
            o_hour             <= r5_hr;
            o_weekday          <= r5_wd;
            o_years_since_1900 <= r5_ys;
            o_day_of_year      <= r5_yday;
            o_month_index      <= w_mon;
            o_day_of_month     <= w_dom_full[4:0];
        end
    end

endmodule

// File: rtl/esc_chk.sv
// Port-level checks for the calendar converter, bound to its top level.
`include "epoch_seconds_to_calendar_core_defines.svh"

module esc_chk
    import esc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [31:0] i_epoch_seconds,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_second,
    input logic [5:0]  o_minute,
    input logic [4:0]  o_hour,
    input logic [2:0]  o_weekday,
    input logic [7:0]  o_years_since_1900,
    input logic [8:0]  o_day_of_year,
    input logic [3:0]  o_month_index,
    input logic [4:0]  o_day_of_month
);

    // A stalled result stays offered.
    `ESC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // A stalled result keeps its year, day of year and second.
    `ESC_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_day_of_year) && $stable(o_years_since_1900) && $stable(o_second))

    // With the output stage empty, every stage can move, so a request is taken.
    `ESC_ASSERT_IMP(a_empty_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // The delivered time of day, weekday and month are legal and the day of month is nonzero.
    `ESC_ASSERT_IMP(a_fields_legal, i_clk, i_rst_n, o_out_valid, (o_second < 6'(SEC_PER_MIN)) && (o_minute < 6'(MIN_PER_HOUR)) && (o_hour < 5'(HOUR_PER_DAY)) && (o_weekday < 3'(DAY_PER_WEEK)) && (o_month_index < 4'(MONTH_PER_YR)) && (o_day_of_month != 5'd0))

endmodule

bind epoch_seconds_to_calendar_core esc_chk u_esc_chk (.*);
